@@ rtl/scsd_pkg.sv @@
// ----------------------------------------------------------------------------
// scsd_pkg
// Shared constants and types for the sine/cosine series block.
// ----------------------------------------------------------------------------
`default_nettype none

package scsd_pkg;

  localparam int unsigned LAST_TERM_DEF = 20;
  localparam int unsigned FRAC_BITS_DEF = 30;

  localparam int unsigned ANGLE_W  = 32;
  localparam int unsigned RESULT_W = 32;
  localparam int unsigned Q_OUT    = 30;

  // one full turn in Q16.16 degrees
  localparam int unsigned RED_W        = 25;
  localparam logic [RED_W-1:0] DEG_FULL = 25'd23592960;
  localparam int unsigned REDUCE_STEPS = 7;

  // pi * 2^32, rounded to nearest
  localparam int unsigned PI_W       = 34;
  localparam logic [PI_W-1:0] PI32   = 34'h3_243F_6A89;
  localparam int unsigned RAD_SCALE  = 48;
  localparam logic [6:0] HALF_180    = 7'd90;

  // exact floor division by reciprocal: dividends below 2^48, divisors below 2^12
  localparam int unsigned RECIP_SHIFT = 60;
  localparam int unsigned RECIP_W     = 60;
  localparam logic [63:0] RECIP_180   = ((64'd1 << RECIP_SHIFT) + 64'd179) / 64'd180;

  localparam int unsigned OPND_W = 64;
  localparam int unsigned PROD_W = 128;

  typedef struct packed {
    logic              start;
    logic [OPND_W-1:0] a;
    logic [OPND_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] p;
  } mul_rsp_t;

endpackage

`default_nettype wire

@@ rtl/scsd_in_if.sv @@
// ----------------------------------------------------------------------------
// scsd_in_if
// Input channel: one angle per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface scsd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [scsd_pkg::ANGLE_W-1:0] angle_deg;

  modport source (output valid, output angle_deg, input ready);
  modport sink (input valid, input angle_deg, output ready);
endinterface

`default_nettype wire

@@ rtl/scsd_out_if.sv @@
// ----------------------------------------------------------------------------
// scsd_out_if
// Output channel: sine and cosine per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface scsd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [scsd_pkg::RESULT_W-1:0] sine_value;
  logic signed [scsd_pkg::RESULT_W-1:0] cosine_value;

  modport source (output valid, output sine_value, output cosine_value, input ready);
  modport sink (input valid, input sine_value, input cosine_value, output ready);
endinterface

`default_nettype wire

@@ rtl/scsd_mul.sv @@
// ----------------------------------------------------------------------------
// scsd_mul
// Iterative 64 x 64 unsigned multiplier over one shared 32 x 32 multiplier,
// four partial products accumulated into a 128-bit register.
// ----------------------------------------------------------------------------
`default_nettype none

module scsd_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  scsd_pkg::mul_req_t req_i,
  output scsd_pkg::mul_rsp_t rsp_o
);

  localparam int unsigned OW = scsd_pkg::OPND_W;
  localparam int unsigned PW = scsd_pkg::PROD_W;
  localparam int unsigned HW = OW / 2;
  localparam logic [1:0] CNT_LAST = 2'd3;

  logic [OW-1:0]   a_q, b_q;
  logic [1:0]      cnt_q;
  logic            busy_q;
  logic            pp_vld_q;
  logic            pp_last_q;
  logic            done_q;
  logic [1:0]      pp_sh_q;
  logic [2*HW-1:0] pp_q;
  logic [PW-1:0]   acc_q;

  logic [HW-1:0]   a_half, b_half;
  logic [PW-1:0]   pp_ext;

  always_comb begin
    a_half = cnt_q[1] ? a_q[OW-1:HW] : a_q[HW-1:0];
    b_half = cnt_q[0] ? b_q[OW-1:HW] : b_q[HW-1:0];
    pp_ext = {{(PW-2*HW){1'b0}}, pp_q} << (HW * pp_sh_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      cnt_q     <= '0;
      pp_vld_q  <= 1'b0;
      pp_last_q <= 1'b0;
      done_q    <= 1'b0;
    end else if (req_i.start) begin
      busy_q    <= 1'b1;
      cnt_q     <= '0;
      pp_vld_q  <= 1'b0;
      pp_last_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      done_q    <= pp_vld_q && pp_last_q;
      pp_vld_q  <= busy_q;
      pp_last_q <= busy_q && (cnt_q == CNT_LAST);
      if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else begin
      if (busy_q) begin
        pp_q    <= a_half * b_half;
        pp_sh_q <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
      end
      if (pp_vld_q) begin
        acc_q <= acc_q + pp_ext;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.p    = acc_q;

endmodule

`default_nettype wire

@@ rtl/sine_cosine_degrees_series_top.sv @@
// ----------------------------------------------------------------------------
// sine_cosine_degrees_series_top
// Sine and cosine of a Q16.16 angle in degrees by Maclaurin series,
// results in Q2.30 clamped to plus or minus one.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  in_i     in   angle_deg (signed Q16.16)
//  out_o    out  sine_value, cosine_value (signed Q2.30)
//
//  Each product goes through the shared 32 x 32 multiplier; a series term
//  takes four products, and the modulo-360 reduction takes seven steps.
//  The input is ready only while idle; a finished beat waits in the output
//  register and a new angle is taken meanwhile. Reset is asynchronous.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_cosine_degrees_series_top #(
  parameter int unsigned LAST_TERM = scsd_pkg::LAST_TERM_DEF,
  parameter int unsigned FRAC_BITS = scsd_pkg::FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  scsd_in_if.sink           in_i,
  scsd_out_if.source        out_o
);

  localparam int unsigned RW      = FRAC_BITS + 3;
  localparam int unsigned R2W     = FRAC_BITS + 6;
  localparam int unsigned TW      = FRAC_BITS + 8;
  localparam int unsigned XW      = FRAC_BITS + 13;
  localparam int unsigned AW      = FRAC_BITS + 11;
  localparam int unsigned KW      = $clog2(LAST_TERM + 1);
  localparam int unsigned TBL_N   = 2 * LAST_TERM + 1;
  localparam int unsigned JW      = $clog2(TBL_N);
  localparam int unsigned HALF_W  = $clog2((TBL_N - 1) * TBL_N);
  localparam int unsigned RCNT_W  = $clog2(scsd_pkg::REDUCE_STEPS);
  localparam int unsigned RAD_SH  = scsd_pkg::RAD_SCALE - FRAC_BITS;
  localparam int unsigned OW      = scsd_pkg::OPND_W;
  localparam int unsigned PW      = scsd_pkg::PROD_W;
  localparam int unsigned RSW     = scsd_pkg::RESULT_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_RAD_MUL,
    ST_RAD_DIV,
    ST_SQR,
    ST_TERM,
    ST_SIN_MUL,
    ST_SIN_DIV,
    ST_COS_MUL,
    ST_COS_DIV,
    ST_FINISH
  } state_e;

  state_e                 state_q;
  logic                   issued_q;
  logic [31:0]            mag_q;
  logic                   neg_q;
  logic [RCNT_W-1:0]      rcnt_q;
  logic [RW-1:0]          rad_q;
  logic [R2W-1:0]         rad2_q;
  logic [XW-1:0]          x_q;
  logic [TW-1:0]          ts_q, tc_q;
  logic                   ts_neg_q, tc_neg_q;
  logic signed [AW-1:0]   acc_s_q, acc_c_q;
  logic [KW-1:0]          k_q;
  logic                   out_valid_q;
  logic [RSW-1:0]         sine_q, cosine_q;

  logic [scsd_pkg::RECIP_W-1:0] recip_tbl [TBL_N];
  logic [HALF_W-1:0]            half_tbl [TBL_N];

  scsd_pkg::mul_req_t     mul_req;
  scsd_pkg::mul_rsp_t     mul_rsp;

  logic [31:0]                  deg_sh;
  logic [scsd_pkg::RED_W-1:0]   red_w;
  logic [JW-1:0]                j_sin, j_cos, j_sel;
  logic                         mul_state;
  logic [PW-1:0]                p_rnd;
  logic [XW-1:0]                n_w;
  logic signed [AW-1:0]         ts_ext, tc_ext;
  logic                         out_hs;

  for (genvar g = 0; g < TBL_N; g++) begin : g_div
    localparam longint unsigned DIV_G = (g == 0) ? 2 : g * (g + 1);
    localparam logic [63:0] RCP_G =
        ((64'd1 << scsd_pkg::RECIP_SHIFT) + 64'(DIV_G) - 64'd1) / 64'(DIV_G);
    assign recip_tbl[g] = RCP_G[scsd_pkg::RECIP_W-1:0];
    assign half_tbl[g]  = HALF_W'(DIV_G / 2);
  end

  function automatic logic [RSW-1:0] sat_scale(input logic signed [AW-1:0] acc);
    logic signed [AW-1:0] one;
    logic signed [AW-1:0] c;
    one = $signed(AW'(1) << FRAC_BITS);
    c   = acc;
    priority if (acc > one) begin
      c = one;
    end else if (acc < -one) begin
      c = -one;
    end
    return RSW'(c) << (scsd_pkg::Q_OUT - FRAC_BITS);
  endfunction

  always_comb begin
    deg_sh = 32'(scsd_pkg::DEG_FULL) << rcnt_q;
    red_w  = (neg_q && (mag_q != 32'd0))
           ? scsd_pkg::DEG_FULL - mag_q[scsd_pkg::RED_W-1:0]
           : mag_q[scsd_pkg::RED_W-1:0];
    j_sin  = JW'({k_q + KW'(1), 1'b0});
    j_cos  = JW'({k_q, 1'b1});
    j_sel  = ((state_q == ST_SIN_MUL) || (state_q == ST_SIN_DIV)) ? j_sin : j_cos;
    p_rnd  = mul_rsp.p + (PW'(1) << (FRAC_BITS - 1));
    n_w    = p_rnd[FRAC_BITS +: XW] + XW'(half_tbl[j_sel]);
    ts_ext = $signed(AW'(ts_q));
    tc_ext = $signed(AW'(tc_q));
    out_hs = out_valid_q && out_o.ready;

    mul_state = 1'b1;
    mul_req.a = '0;
    mul_req.b = '0;
    unique case (state_q)
      ST_RAD_MUL: begin
        mul_req.a = OW'(red_w);
        mul_req.b = OW'(scsd_pkg::PI32);
      end
      ST_RAD_DIV: begin
        mul_req.a = OW'(x_q);
        mul_req.b = OW'(scsd_pkg::RECIP_180);
      end
      ST_SQR: begin
        mul_req.a = OW'(rad_q);
        mul_req.b = OW'(rad_q);
      end
      ST_SIN_MUL: begin
        mul_req.a = OW'(ts_q);
        mul_req.b = OW'(rad2_q);
      end
      ST_COS_MUL: begin
        mul_req.a = OW'(tc_q);
        mul_req.b = OW'(rad2_q);
      end
      ST_SIN_DIV, ST_COS_DIV: begin
        mul_req.a = OW'(x_q);
        mul_req.b = OW'(recip_tbl[j_sel]);
      end
      default: begin
        mul_state = 1'b0;
      end
    endcase
    mul_req.start = mul_state && !issued_q;
  end

  scsd_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= 1'b0;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      rcnt_q      <= '0;
      rad_q       <= '0;
      rad2_q      <= '0;
      x_q         <= '0;
      ts_q        <= '0;
      tc_q        <= '0;
      ts_neg_q    <= 1'b0;
      tc_neg_q    <= 1'b0;
      acc_s_q     <= '0;
      acc_c_q     <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      sine_q      <= '0;
      cosine_q    <= '0;
    end else begin
      if (out_hs && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      if (mul_req.start) begin
        issued_q <= 1'b1;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            mag_q   <= in_i.angle_deg[31] ? 32'(-in_i.angle_deg) : 32'(in_i.angle_deg);
            neg_q   <= in_i.angle_deg[31];
            rcnt_q  <= RCNT_W'(scsd_pkg::REDUCE_STEPS - 1);
            state_q <= ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          if (mag_q >= deg_sh) begin
            mag_q <= mag_q - deg_sh;
          end
          rcnt_q <= rcnt_q - RCNT_W'(1);
          if (rcnt_q == '0) begin
            state_q <= ST_RAD_MUL;
          end
        end
        ST_RAD_MUL: begin
          if (issued_q && mul_rsp.done) begin
            issued_q <= 1'b0;
            x_q      <= mul_rsp.p[RAD_SH +: XW] + XW'(scsd_pkg::HALF_180);
            state_q  <= ST_RAD_DIV;
          end
        end
        ST_RAD_DIV: begin
          if (issued_q && mul_rsp.done) begin
            issued_q <= 1'b0;
            rad_q    <= mul_rsp.p[scsd_pkg::RECIP_SHIFT +: RW];
            state_q  <= ST_SQR;
          end
        end
        ST_SQR: begin
          if (issued_q && mul_rsp.done) begin
            issued_q <= 1'b0;
            rad2_q   <= p_rnd[FRAC_BITS +: R2W];
            ts_q     <= TW'(rad_q);
            ts_neg_q <= 1'b0;
            tc_q     <= TW'(1) << FRAC_BITS;
            tc_neg_q <= 1'b0;
            acc_s_q  <= '0;
            acc_c_q  <= '0;
            k_q      <= '0;
            state_q  <= ST_TERM;
          end
        end
        ST_TERM: begin
          acc_s_q <= ts_neg_q ? acc_s_q - ts_ext : acc_s_q + ts_ext;
          acc_c_q <= tc_neg_q ? acc_c_q - tc_ext : acc_c_q + tc_ext;
          if (k_q == KW'(LAST_TERM)) begin
            state_q <= ST_FINISH;
          end else begin
            state_q <= ST_SIN_MUL;
          end
        end
        ST_SIN_MUL: begin
          if (issued_q && mul_rsp.done) begin
            issued_q <= 1'b0;
            x_q      <= n_w;
            state_q  <= ST_SIN_DIV;
          end
        end
        ST_SIN_DIV: begin
          if (issued_q && mul_rsp.done) begin
            issued_q <= 1'b0;
            ts_q     <= mul_rsp.p[scsd_pkg::RECIP_SHIFT +: TW];
            ts_neg_q <= !ts_neg_q;
            state_q  <= ST_COS_MUL;
          end
        end
        ST_COS_MUL: begin
          if (issued_q && mul_rsp.done) begin
            issued_q <= 1'b0;
            x_q      <= n_w;
            state_q  <= ST_COS_DIV;
          end
        end
        ST_COS_DIV: begin
          if (issued_q && mul_rsp.done) begin
            issued_q <= 1'b0;
            tc_q     <= mul_rsp.p[scsd_pkg::RECIP_SHIFT +: TW];
            tc_neg_q <= !tc_neg_q;
            k_q      <= k_q + KW'(1);
            state_q  <= ST_TERM;
          end
        end
        ST_FINISH: begin
          if (!out_valid_q || out_o.ready) begin
            sine_q      <= sat_scale(acc_s_q);
            cosine_q    <= sat_scale(acc_c_q);
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.sine_value   = sine_q;
  assign out_o.cosine_value = cosine_q;

endmodule

`default_nettype wire

@@ rtl/scsd_checker.sv @@
// ----------------------------------------------------------------------------
// scsd_checker
// Port-level checks on the sine/cosine series block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module scsd_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_i,
  input logic                                 out_valid_i,
  input logic                                 out_ready_i,
  input logic signed [scsd_pkg::RESULT_W-1:0] sine_value_i,
  input logic signed [scsd_pkg::RESULT_W-1:0] cosine_value_i
);

  localparam logic signed [scsd_pkg::RESULT_W-1:0] ONE_Q =
      $signed(scsd_pkg::RESULT_W'(1) << scsd_pkg::Q_OUT);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input still ready after an angle beat");

  a_result_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (sine_value_i <= ONE_Q) && (sine_value_i >= -ONE_Q) &&
                    (cosine_value_i <= ONE_Q) && (cosine_value_i >= -ONE_Q))
    else $error("result beyond plus or minus one");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result beat appeared without a busy period");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
                                    $stable(sine_value_i) && $stable(cosine_value_i))
    else $error("stalled result beat changed");

endmodule

bind sine_cosine_degrees_series_top scsd_checker u_scsd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .sine_value_i   (out_o.sine_value),
  .cosine_value_i (out_o.cosine_value)
);

`default_nettype wire

@@ tb/tb_sine_cosine_degrees_series_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sine_cosine_degrees_series_top
// Feeds Q16.16 angles through the series block, first from a short table of
// corner angles and then at random, and checks every beat against table values
// or a bit-exact series model in this bench. Both channels stall at random.
// ----------------------------------------------------------------------------

module tb_sine_cosine_degrees_series_top;

  localparam int unsigned SERIES_LAST = scsd_pkg::LAST_TERM_DEF;
  localparam int unsigned Q_FRAC      = scsd_pkg::FRAC_BITS_DEF;
  localparam int unsigned LATENCY     = 30 + 29 * SERIES_LAST;

  localparam int          DEG1         = 65536;
  localparam logic [31:0] ONE_Q30      = 32'h4000_0000;
  localparam int          N_DIRECTED   = 23;
  localparam int          N_RANDOM     = 1327;
  localparam int          N_TOTAL      = N_DIRECTED + N_RANDOM;
  localparam int          QUIET_ITEMS  = 100;
  localparam int          PAUSE_AT     = 700;
  localparam int          HOLD_AT      = 300;
  localparam int          LONG_HOLD    = 2500;
  localparam int          WATCHDOG_MAX = 20000;

  typedef struct packed {
    logic [31:0] angle;
    logic        known;
    logic [31:0] sine;
    logic [31:0] cosine;
  } angle_row_t;

  typedef struct packed {
    logic        [31:0] angle;
    logic signed [31:0] sine;
    logic signed [31:0] cosine;
  } trig_pair_t;

  localparam angle_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{32'(0),              1'b1, 32'(0), ONE_Q30},
    '{32'(360 * DEG1),     1'b1, 32'(0), ONE_Q30},
    '{32'(-360 * DEG1),    1'b1, 32'(0), ONE_Q30},
    '{32'(32760 * DEG1),   1'b1, 32'(0), ONE_Q30},
    '{32'(-32760 * DEG1),  1'b1, 32'(0), ONE_Q30},
    '{32'(90 * DEG1),      1'b0, 32'(0), 32'(0)},
    '{32'(-90 * DEG1),     1'b0, 32'(0), 32'(0)},
    '{32'(270 * DEG1),     1'b0, 32'(0), 32'(0)},
    '{32'(180 * DEG1),     1'b0, 32'(0), 32'(0)},
    '{32'(-180 * DEG1),    1'b0, 32'(0), 32'(0)},
    '{32'(45 * DEG1),      1'b0, 32'(0), 32'(0)},
    '{32'(30 * DEG1),      1'b0, 32'(0), 32'(0)},
    '{32'(60 * DEG1),      1'b0, 32'(0), 32'(0)},
    '{32'(-135 * DEG1),    1'b0, 32'(0), 32'(0)},
    '{32'(1),              1'b0, 32'(0), 32'(0)},
    '{32'hFFFF_FFFF,       1'b0, 32'(0), 32'(0)},
    '{32'h7FFF_FFFF,       1'b0, 32'(0), 32'(0)},
    '{32'h8000_0000,       1'b0, 32'(0), 32'(0)},
    '{32'(360 * DEG1 - 1), 1'b0, 32'(0), 32'(0)},
    '{32'(90 * DEG1 - 1),  1'b0, 32'(0), 32'(0)},
    '{32'(90 * DEG1 + 1),  1'b0, 32'(0), 32'(0)},
    '{32'h5555_5555,       1'b0, 32'(0), 32'(0)},
    '{32'hAAAA_AAAA,       1'b0, 32'(0), 32'(0)}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  scsd_in_if  in_if ();
  scsd_out_if out_if ();

  trig_pair_t pending_pairs [$];
  int         angles_sent   = 0;
  int         pairs_checked = 0;
  int         errors        = 0;
  int         quiet_cycles  = 0;
  bit         idling_on     = 1'b1;
  bit         long_hold_done = 1'b0;

  always #10 clk_i = ~clk_i;

  sine_cosine_degrees_series_top #(
    .LAST_TERM(SERIES_LAST),
    .FRAC_BITS(Q_FRAC)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // rounded fixed-point product, halves away from zero
  function automatic longint fx_mul(input longint a, input longint b);
    logic         neg;
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [128:0] prod;
    logic [61:0]  mag;
    neg  = (a < 0) != (b < 0);
    ma   = (a < 0) ? -a : a;
    mb   = (b < 0) ? -b : b;
    prod = 129'(ma) * 129'(mb);
    prod = prod + (129'd1 << (Q_FRAC - 1));
    mag  = prod[Q_FRAC +: 62];
    return neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
  endfunction

  function automatic longint div_round(input longint v, input longint d);
    if (v >= 0) return (v + d / 2) / d;
    return -((-v + d / 2) / d);
  endfunction

  function automatic logic [31:0] clamp_q230(input longint acc);
    longint one;
    one = longint'(1) <<< Q_FRAC;
    if (acc > one) acc = one;
    if (acc < -one) acc = -one;
    acc = acc * (longint'(1) <<< (30 - Q_FRAC));
    return acc[31:0];
  endfunction

  function automatic trig_pair_t series_sin_cos(input logic signed [31:0] angle);
    trig_pair_t pair;
    longint     turn;
    longint     red;
    longint     rad;
    longint     rad2;
    longint     ts;
    longint     tc;
    longint     acc_s;
    longint     acc_c;
    logic [63:0] num;
    logic [63:0] den;
    turn = longint'(scsd_pkg::DEG_FULL);
    red  = longint'(angle) % turn;
    if (red < 0) red += turn;
    num  = 64'(red) * 64'(scsd_pkg::PI32);
    den  = 64'd180 << (scsd_pkg::RAD_SCALE - Q_FRAC);
    rad  = longint'((num + den / 2) / den);
    rad2 = fx_mul(rad, rad);
    ts    = rad;
    tc    = longint'(1) <<< Q_FRAC;
    acc_s = 0;
    acc_c = 0;
    for (int k = 0; k <= SERIES_LAST; k++) begin
      acc_s += ts;
      acc_c += tc;
      ts = -div_round(fx_mul(ts, rad2), longint'((2 * k + 2) * (2 * k + 3)));
      tc = -div_round(fx_mul(tc, rad2), longint'((2 * k + 1) * (2 * k + 2)));
    end
    pair.angle  = angle;
    pair.sine   = clamp_q230(acc_s);
    pair.cosine = clamp_q230(acc_c);
    return pair;
  endfunction

  task automatic offer_angle(input logic [31:0] angle, input logic known,
                             input logic [31:0] sine, input logic [31:0] cosine);
    trig_pair_t want;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.angle_deg <= angle;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (known) begin
      want.angle  = angle;
      want.sine   = sine;
      want.cosine = cosine;
    end else begin
      want = series_sin_cos(angle);
    end
    pending_pairs.push_back(want);
    angles_sent++;
  endtask

  initial begin : angle_source
    logic [31:0] a;
    int          mode;
    int          turns;
    int          quarter;
    int          off;
    in_if.valid     <= 1'b0;
    in_if.angle_deg <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED_ROWS[i]) begin
      offer_angle(DIRECTED_ROWS[i].angle, DIRECTED_ROWS[i].known,
                  DIRECTED_ROWS[i].sine, DIRECTED_ROWS[i].cosine);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (angles_sent == PAUSE_AT) begin
        in_if.valid <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end
      if (angles_sent >= N_TOTAL - QUIET_ITEMS) idling_on = 1'b0;
      mode = $urandom_range(0, 9);
      if (mode < 4) begin
        a = $urandom;
      end else if (mode < 7) begin
        a = $urandom_range(0, 1440 * DEG1);
        a = a - 32'(720 * DEG1);
      end else if (mode < 9) begin
        turns = $urandom_range(0, 32);
        off   = $urandom_range(0, 510);
        a     = 32'((turns - 16) * 45 * DEG1 + off - 255);
      end else begin
        turns   = $urandom_range(0, 180);
        quarter = $urandom_range(0, 3);
        a       = 32'(((turns - 90) * 360 + quarter * 90) * DEG1);
      end
      offer_angle(a, 1'b0, '0, '0);
    end
    in_if.valid <= 1'b0;

    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 50) @(posedge clk_i);
    $display("Covered %0d angles (%0d corner rows, %0d random), %0d sine/cosine beats checked,",
             angles_sent, N_DIRECTED, angles_sent - N_DIRECTED, pairs_checked);
    $display("with random stalls on both channels, one long output hold and one drained pause.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : result_sink
    out_if.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!long_hold_done && pairs_checked >= HOLD_AT) begin
        long_hold_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : result_check
    trig_pair_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_pairs.size() == 0) begin
        $display("%0t: beat with no angle pending: sine %h cosine %h",
                 $time, out_if.sine_value, out_if.cosine_value);
        errors++;
      end else begin
        want = pending_pairs.pop_front();
        if (out_if.sine_value !== want.sine) begin
          $display("%0t: sine of angle %h: expected %h, actual %h",
                   $time, want.angle, want.sine, out_if.sine_value);
          errors++;
        end
        if (out_if.cosine_value !== want.cosine) begin
          $display("%0t: cosine of angle %h: expected %h, actual %h",
                   $time, want.angle, want.cosine, out_if.cosine_value);
          errors++;
        end
        pairs_checked++;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("%0t: no beat on either channel for %0d cycles", $time, quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule

@@ files.f @@
rtl/scsd_pkg.sv
rtl/scsd_in_if.sv
rtl/scsd_out_if.sv
rtl/scsd_mul.sv
rtl/sine_cosine_degrees_series_top.sv
rtl/scsd_checker.sv
tb/tb_sine_cosine_degrees_series_top.sv
